// ===== rtl/uvs_pkg.sv =====
// Shared types and constants for the unique value stack.
`default_nettype none
package uvs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int PUSH_W        = 32;
   localparam int VALUE_W       = 31;
   localparam int STATUS_W      = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NEGATIVE  = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_VALUE = 2'd1,
      SRC_RDATA = 2'd2
   } res_src_type;

   typedef struct packed {
      logic        load;
      logic        scan_start;
      logic        scan_step;
      logic        push_write;
      logic        pop;
      logic        res_set;
      status_type  res_status;
      res_src_type res_src;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_pop;
      logic in_negative;
      logic empty;
      logic full;
      logic match;
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/uvs_ifs.sv =====
// Request and response channel interfaces for the unique value stack.
`default_nettype none
interface uvs_req_if;
   import uvs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [PUSH_W-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink (input valid, input op, input push_value, output ready);
endinterface

interface uvs_rsp_if;
   import uvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink (input valid, input status, input result_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/unique_value_stack.sv =====
// Top level of the unique value stack.
// A bounded last-in first-out store of DEPTH non-negative 31-bit values that
// refuses duplicates. A push word with a negative value answers status 1; a
// value already stored answers 2; a push into a full store answers 3; else the
// value is stored and echoed with status 0. A pop answers the youngest value
// with status 0, or status 4 and zero when empty. One request is in work at a
// time; the response sits in an output register, so the next request is taken
// while it waits. For a push of a non-negative value the stored entries are
// compared one per cycle through the single read port of the entry memory,
// and the scan stops at the first duplicate. A pop reads the youngest entry
// through the same port; a rejected negative push or a pop of an empty store
// needs no memory read.
`default_nettype none
module unique_value_stack #(
   parameter int DEPTH = uvs_pkg::DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   uvs_req_if.sink    req_chan,
   uvs_rsp_if.source  rsp_chan
);
   import uvs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   uvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   uvs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_chan.op),
      .req_push_value   (req_chan.push_value),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_chan.status),
      .rsp_result_value (rsp_chan.result_value)
   );

endmodule
`default_nettype wire

// ===== rtl/uvs_ctrl.sv =====
// Controller state machine: sequences accept, duplicate scan, pop and response.
`default_nettype none
module uvs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire uvs_pkg::sts_type sts,
   output uvs_pkg::cmd_type      cmd
);
   import uvs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_POP    = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = ST_OK;
      cmd.res_src    = SRC_ZERO;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (sts.in_pop && sts.empty) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_EMPTY;
                  state_in       = S_FINISH;
               end else if (sts.in_pop) begin
                  cmd.pop  = 1'b1;
                  state_in = S_POP;
               end else if (sts.in_negative) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_NEGATIVE;
                  state_in       = S_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            priority if (sts.match) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_DUPLICATE;
               state_in       = S_FINISH;
            end else if (sts.scan_done && sts.full) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_FINISH;
            end else if (sts.scan_done) begin
               cmd.push_write = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_src    = SRC_VALUE;
               state_in       = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_POP: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_src    = SRC_RDATA;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/uvs_datapath.sv =====
// Datapath: entry memory, fill count, scan counter, comparator and result registers.
`default_nettype none
module uvs_datapath #(
   parameter int DEPTH = uvs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_op,
   input  wire logic signed [uvs_pkg::PUSH_W-1:0] req_push_value,
   input  wire uvs_pkg::cmd_type                 cmd,
   output uvs_pkg::sts_type                      sts,
   output logic [uvs_pkg::STATUS_W-1:0]          rsp_status,
   output logic [uvs_pkg::VALUE_W-1:0]           rsp_result_value
);
   import uvs_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);
   localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

   logic [VALUE_W-1:0]  entries [0:DEPTH-1];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;

   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   scan_ff, scan_in;
   logic                cmp_pend_ff, cmp_pend_in;
   logic [VALUE_W-1:0]  value_ff;
   logic [FILL_W-1:0]   fill_dec;
   logic                scan_more;

   status_type          res_status_ff;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;

   assign fill_dec  = fill_ff - FILL_ONE;
   assign scan_more = (scan_ff < fill_ff);
   assign rd_addr   = cmd.pop ? fill_dec[IDX_W-1:0] : scan_ff[IDX_W-1:0];

   assign sts.in_pop      = req_op;
   assign sts.in_negative = req_push_value[PUSH_W-1];
   assign sts.empty       = (fill_ff == '0);
   assign sts.full        = (fill_ff == FILL_MAX);
   assign sts.match       = cmp_pend_ff && (rd_data_ff == value_ff);
   assign sts.scan_done   = !cmp_pend_ff && !scan_more;

   always_comb begin
      fill_in     = fill_ff;
      scan_in     = scan_ff;
      cmp_pend_in = 1'b0;
      if (cmd.push_write) begin
         fill_in = fill_ff + FILL_ONE;
      end else if (cmd.pop) begin
         fill_in = fill_dec;
      end
      if (cmd.scan_start) begin
         scan_in = '0;
      end else if (cmd.scan_step && scan_more) begin
         scan_in     = scan_ff + FILL_ONE;
         cmp_pend_in = 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.res_src)
         SRC_VALUE: res_value_in = value_ff;
         SRC_RDATA: res_value_in = rd_data_ff;
         default:   res_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.push_write) begin
         entries[fill_ff[IDX_W-1:0]] <= value_ff;
      end
      rd_data_ff <= entries[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         scan_ff     <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         scan_ff     <= scan_in;
         cmp_pend_ff <= cmp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_push_value[VALUE_W-1:0];
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= res_value_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule
`default_nettype wire
